@@ rtl/tclp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types and constants of the text command line parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

  localparam int PeriodBits = 16;
  localparam int MagW       = PeriodBits;
  localparam int AccW       = MagW + 4;
  localparam int PerExtW    = MagW + 1;
  localparam int OutPerW    = 17;
  localparam int WideW      = (PerExtW > OutPerW) ? PerExtW : OutPerW;

  localparam int ByteW      = 8;
  localparam int LenW       = 4;
  localparam int HeadLen    = 7;
  localparam int HeadIdxW   = 3;
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 16;

  localparam logic [LenW-1:0] LenSat = LenW'(8);

  localparam logic [ByteW-1:0] AsciiNul   = 8'h00;
  localparam logic [ByteW-1:0] AsciiEot   = 8'h04;
  localparam logic [ByteW-1:0] AsciiTab   = 8'h09;
  localparam logic [ByteW-1:0] AsciiLf    = 8'h0A;
  localparam logic [ByteW-1:0] AsciiCr    = 8'h0D;
  localparam logic [ByteW-1:0] AsciiSpace = 8'h20;
  localparam logic [ByteW-1:0] AsciiPlus  = 8'h2B;
  localparam logic [ByteW-1:0] AsciiMinus = 8'h2D;
  localparam logic [ByteW-1:0] AsciiZero  = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine  = 8'h39;

  localparam logic [23:0] WordOff   = "OFF";
  localparam logic [31:0] WordStop  = "STOP";
  localparam logic [39:0] WordStart = "START";
  localparam logic [55:0] WordScf   = "SCALE=F";
  localparam logic [55:0] WordScc   = "SCALE=C";
  localparam logic [55:0] WordPer   = "PERIOD=";

  typedef enum logic [2:0] {
    CmdOther  = 3'd0,
    CmdOff    = 3'd1,
    CmdStop   = 3'd2,
    CmdStart  = 3'd3,
    CmdScaleF = 3'd4,
    CmdScaleC = 3'd5,
    CmdPeriod = 3'd6
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegInitialPeriod     = 4'd0,
    RegInitialFahrenheit = 4'd1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PhSkip   = 3'b001,
    PhDigits = 3'b010,
    PhDone   = 3'b100
  } phase_e;

  typedef struct packed {
    logic en;
    logic newline;
  } line_step_t;

  typedef struct packed {
    logic take;
    logic clear;
  } num_step_t;

endpackage : tclp_pkg
`default_nettype wire

@@ rtl/tclp_byte_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_byte_if
// Byte stream channel: one text byte per beat.
// ----------------------------------------------------------------------------
interface tclp_byte_if;
  import tclp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface : tclp_byte_if
`default_nettype wire

@@ rtl/tclp_result_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_result_if
// Result channel: one parsed line per beat.
// ----------------------------------------------------------------------------
interface tclp_result_if;
  import tclp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [2:0]                command_code;
  logic signed [OutPerW-1:0] period_value;
  logic                      running;
  logic                      fahrenheit;

  modport source (output valid, output command_code, output period_value,
                  output running, output fahrenheit, input ready);
  modport sink   (input valid, input command_code, input period_value,
                  input running, input fahrenheit, output ready);
endinterface : tclp_result_if
`default_nettype wire

@@ rtl/tclp_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface tclp_cfg_if;
  import tclp_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : tclp_cfg_if
`default_nettype wire

@@ rtl/tclp_line.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_line
// Line length and head byte capture, keyword classification at newline.
// ----------------------------------------------------------------------------
module tclp_line
  import tclp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire line_step_t       step_i,
  input  wire logic [ByteW-1:0] byte_i,
  output      num_step_t        num_step_o,
  output      cmd_e             cmd_o
);

  logic [LenW-1:0]  len_q, len_d;
  logic [ByteW-1:0] head_q [HeadLen];
  logic             discard;
  logic             head_wr;
  logic [55:0]      head7;

  assign discard = (len_q == '0) && ((byte_i == AsciiNul) || (byte_i == AsciiEot));
  assign head_wr = step_i.en && !step_i.newline && !discard && (len_q < LenW'(HeadLen));

  always_comb begin
    len_d = len_q;
    if (step_i.en) begin
      if (step_i.newline) begin
        len_d = '0;
      end else if (!discard && (len_q < LenSat)) begin
        len_d = len_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_wr) begin
      head_q[len_q[HeadIdxW-1:0]] <= byte_i;
    end
  end

  assign num_step_o.take  = step_i.en && !step_i.newline && (len_q >= LenW'(HeadLen));
  assign num_step_o.clear = step_i.en && step_i.newline;

  assign head7 = {head_q[0], head_q[1], head_q[2], head_q[3],
                  head_q[4], head_q[5], head_q[6]};

  always_comb begin
    cmd_o = CmdOther;
    unique case (len_q)
      LenW'(3): if (head7[55:32] == WordOff)   cmd_o = CmdOff;
      LenW'(4): if (head7[55:24] == WordStop)  cmd_o = CmdStop;
      LenW'(5): if (head7[55:16] == WordStart) cmd_o = CmdStart;
      LenW'(7): begin
        if (head7 == WordScf) begin
          cmd_o = CmdScaleF;
        end else if (head7 == WordScc) begin
          cmd_o = CmdScaleC;
        end
      end
      LenSat: if (head7 == WordPer) cmd_o = CmdPeriod;
      default: cmd_o = CmdOther;
    endcase
  end

endmodule : tclp_line
`default_nettype wire

@@ rtl/tclp_number.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tclp_number
// Decimal number reader: whitespace skip, sign, saturating digit accumulate.
// ----------------------------------------------------------------------------
module tclp_number
  import tclp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire num_step_t        step_i,
  input  wire logic [ByteW-1:0] byte_i,
  output      logic             neg_o,
  output      logic [MagW-1:0]  mag_o
);

  localparam logic [AccW-1:0] MagMax = AccW'({MagW{1'b1}});

  phase_e          phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic            is_ws, is_sign, is_digit, digit_path;
  logic [AccW-1:0] acc;

  assign is_ws    = (byte_i == AsciiSpace) || ((byte_i >= AsciiTab) && (byte_i <= AsciiCr));
  assign is_sign  = (byte_i == AsciiPlus) || (byte_i == AsciiMinus);
  assign is_digit = (byte_i >= AsciiZero) && (byte_i <= AsciiNine);

  // times ten as shift and add
  assign acc = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + AccW'(byte_i - AsciiZero);

  assign digit_path = (phase_q == PhDigits) || ((phase_q == PhSkip) && !is_ws && !is_sign);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (step_i.clear) begin
      phase_d = PhSkip;
      neg_d   = 1'b0;
      mag_d   = '0;
    end else if (step_i.take) begin
      if (digit_path) begin
        if (is_digit) begin
          phase_d = PhDigits;
          mag_d   = (acc > MagMax) ? MagMax[MagW-1:0] : acc[MagW-1:0];
        end else begin
          phase_d = PhDone;
        end
      end else if ((phase_q == PhSkip) && is_sign) begin
        phase_d = PhDigits;
        neg_d   = (byte_i == AsciiMinus);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
    end
  end

  assign neg_o = neg_q;
  assign mag_o = mag_q;

endmodule : tclp_number
`default_nettype wire

@@ rtl/text_command_line_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_command_line_parser
// Line command parser: input beat register, line/number trackers, result reg.
// ----------------------------------------------------------------------------
// A newline beat gives its result beat through the input register, then the
// result register. One byte beat per cycle is taken, but a newline beat stalls
// while the result register holds a beat that is not yet accepted.
// Reset: asynchronous, active low; period 1, running, Fahrenheit, line empty.
// After OFF every byte is taken and dropped until reset.
// ----------------------------------------------------------------------------
module text_command_line_parser
  import tclp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tclp_byte_if.sink   char_i,
  tclp_cfg_if.sink    cfg_i,
  tclp_result_if.source result_o
);

  logic                      in_valid_q;
  logic [ByteW-1:0]          in_byte_q;
  logic                      newline, emit, out_free, fire;

  logic signed [OutPerW-1:0] period_q, period_d;
  logic                      run_q, run_d;
  logic                      scale_q, scale_d;
  logic                      halted_q;

  logic                      out_valid_q;
  cmd_e                      out_cmd_q;
  logic signed [OutPerW-1:0] out_period_q;
  logic                      out_run_q;
  logic                      out_scale_q;

  line_step_t                line_step;
  num_step_t                 num_step;
  cmd_e                      cmd;
  logic                      num_neg;
  logic [MagW-1:0]           num_mag;
  logic signed [PerExtW-1:0] sval;
  logic signed [WideW-1:0]   swide;

  assign newline  = (in_byte_q == AsciiLf);
  assign emit     = newline && !halted_q;
  assign out_free = !out_valid_q || result_o.ready;
  assign fire     = in_valid_q && (!emit || out_free);

  assign char_i.ready = !in_valid_q || fire;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      in_byte_q <= char_i.char_byte;
    end
  end

  assign line_step.en      = fire && !halted_q;
  assign line_step.newline = newline;

  tclp_line u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (line_step),
    .byte_i     (in_byte_q),
    .num_step_o (num_step),
    .cmd_o      (cmd)
  );

  tclp_number u_number (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (num_step),
    .byte_i (in_byte_q),
    .neg_o  (num_neg),
    .mag_o  (num_mag)
  );

  assign sval  = num_neg ? -signed'({1'b0, num_mag}) : signed'({1'b0, num_mag});
  assign swide = WideW'(sval);

  always_comb begin
    period_d = period_q;
    run_d    = run_q;
    scale_d  = scale_q;
    unique case (cmd)
      CmdStop:   run_d    = 1'b0;
      CmdStart:  run_d    = 1'b1;
      CmdScaleF: scale_d  = 1'b1;
      CmdScaleC: scale_d  = 1'b0;
      CmdPeriod: period_d = swide[OutPerW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= OutPerW'(1);
      run_q    <= 1'b1;
      scale_q  <= 1'b1;
      halted_q <= 1'b0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegInitialPeriod) begin
        period_q <= {1'b0, cfg_i.data};
      end else if (cfg_i.index == RegInitialFahrenheit) begin
        scale_q <= cfg_i.data[0];
      end
    end else if (fire && emit) begin
      period_q <= period_d;
      run_q    <= run_d;
      scale_q  <= scale_d;
      halted_q <= (cmd == CmdOff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_cmd_q    <= cmd;
      out_period_q <= period_d;
      out_run_q    <= run_d;
      out_scale_q  <= scale_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.command_code = out_cmd_q;
  assign result_o.period_value = out_period_q;
  assign result_o.running      = out_run_q;
  assign result_o.fahrenheit   = out_scale_q;

endmodule : text_command_line_parser
`default_nettype wire
